/* rtl/core/sfog_pkg.sv */
// ----------------------------------------------------------------------------
// sfog_pkg
// Shared types and constants for the stereo fade-out gain block: sequencer
// states, control and status bundles, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package sfog_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned VOL_W    = 20;
  localparam int unsigned QUOT_W   = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_START    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = 2'd2;

  localparam logic [VOL_W-1:0] MASTER_RESET      = 20'h10000;
  localparam logic [POS_W-1:0] FADE_START_RESET  = 32'd0;
  localparam logic [POS_W-1:0] FADE_LENGTH_RESET = 32'd176400;
  localparam logic [QUOT_W:0]  UNITY_GAIN        = 17'h10000;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,
    ST_DIV    = 9'b000000100,
    ST_MUL_FF = 9'b000001000,
    ST_MUL_G  = 9'b000010000,
    ST_LD_G   = 9'b000100000,
    ST_MUL_L  = 9'b001000000,
    ST_MUL_R  = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic div;
    logic mul_ff;
    logic mul_g;
    logic ld_g;
    logic mul_l;
    logic mul_r;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic end_hit;
    logic need_div;
    logic out_busy;
    logic ended;
  } stat_t;

endpackage

/* rtl/core/stereo_fade_out_gain.sv */
// ----------------------------------------------------------------------------
// stereo_fade_out_gain
// Master volume and quadratic fade-out on stereo samples, saturated to 16 bits.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | in_sample_pos, in_left_in, in_right_in
//  out     | out_valid/out_stall| out_left_out, out_right_out,
//          |                    | out_sample_valid, out_fade_done
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request inside the fade goes from acceptance to the result register
// through one range check, 16 restoring divide steps, then four passes of
// the shared multiplier plus a gain load; outside it, check and two passes,
// and for the request that ends the fade the check alone. One request is in
// flight at a time; in_stall is high while it is worked on, and the last
// step holds while a previous result is stalled. Synchronous reset restores the
// register defaults and clears the ended flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_fade_out_gain (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sfog_pkg::POS_W-1:0]           in_sample_pos,
  input  logic signed [sfog_pkg::SAMPLE_W-1:0] in_left_in,
  input  logic signed [sfog_pkg::SAMPLE_W-1:0] in_right_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sfog_pkg::OUT_W-1:0]    out_left_out,
  output logic signed [sfog_pkg::OUT_W-1:0]    out_right_out,
  output logic                                 out_sample_valid,
  output logic                                 out_fade_done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sfog_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfog_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sfog_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  idle;

  sfog_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl),
    .idle     (idle)
  );

  sfog_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_sample_pos    (in_sample_pos),
    .in_left_in       (in_left_in),
    .in_right_in      (in_right_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_out     (out_left_out),
    .out_right_out    (out_right_out),
    .out_sample_valid (out_sample_valid),
    .out_fade_done    (out_fade_done)
  );

  assign in_stall  = !idle;
  assign cfg_ready = idle;

`ifndef NO_ASSERTIONS
  a_drop_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |-> out_fade_done)
    else $error("dropped sample without fade_done");

  a_drop_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |-> out_left_out == '0 && out_right_out == '0)
    else $error("dropped sample carries non-zero data");

  a_cfg_clears_end: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == REG_MASTER_VOLUME || cfg_index == REG_FADE_START ||
     cfg_index == REG_FADE_LENGTH) |=> !stat.ended)
    else $error("ended flag survived a configuration write");

  a_end_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.ended) |-> $past(ctl.check) && $past(stat.end_hit))
    else $error("ended flag set outside the range check");
`endif

endmodule

/* rtl/core/sfog_seq.sv */
// ----------------------------------------------------------------------------
// sfog_seq
// Sequencer: walks one request through range check, then inside the fade
// sixteen restoring divide steps and four multiplier passes (else two or none).
// ----------------------------------------------------------------------------
module sfog_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  sfog_pkg::stat_t stat,
  output sfog_pkg::ctl_t  ctl,
  output logic           idle
);
  import sfog_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_nxt = '0;
        if (stat.end_hit) state_nxt = ST_FIN;
        else if (stat.need_div) state_nxt = ST_DIV;
        else state_nxt = ST_MUL_L;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_MUL_FF;
      end
      ST_MUL_FF: state_nxt = ST_MUL_G;
      ST_MUL_G:  state_nxt = ST_LD_G;
      ST_LD_G:   state_nxt = ST_MUL_L;
      ST_MUL_L:  state_nxt = ST_MUL_R;
      ST_MUL_R:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign idle       = (state_r == ST_IDLE);
  assign ctl.accept = idle && in_valid;
  assign ctl.check  = (state_r == ST_CHECK);
  assign ctl.div    = (state_r == ST_DIV);
  assign ctl.mul_ff = (state_r == ST_MUL_FF);
  assign ctl.mul_g  = (state_r == ST_MUL_G);
  assign ctl.ld_g   = (state_r == ST_LD_G);
  assign ctl.mul_l  = (state_r == ST_MUL_L);
  assign ctl.mul_r  = (state_r == ST_MUL_R);
  assign ctl.fin    = (state_r == ST_FIN);

endmodule

/* rtl/core/sfog_dp.sv */
// ----------------------------------------------------------------------------
// sfog_dp
// Datapath: configuration registers, ended flag, divide step unit, one
// shared signed multiplier with product register, and result registers.
// ----------------------------------------------------------------------------
module sfog_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sfog_pkg::ctl_t                      ctl,
  output sfog_pkg::stat_t                     stat,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [sfog_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfog_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sfog_pkg::POS_W-1:0]          in_sample_pos,
  input  logic signed [sfog_pkg::SAMPLE_W-1:0] in_left_in,
  input  logic signed [sfog_pkg::SAMPLE_W-1:0] in_right_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sfog_pkg::OUT_W-1:0]   out_left_out,
  output logic signed [sfog_pkg::OUT_W-1:0]   out_right_out,
  output logic                                out_sample_valid,
  output logic                                out_fade_done
);
  import sfog_pkg::*;

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [55:0] p);
    logic [16:0] top;
    top = p[55:39];
    if (top == '0 || top == '1) sat16 = p[39:24];
    else if (p[55]) sat16 = 16'sh8000;
    else sat16 = 16'sh7FFF;
  endfunction

  logic [VOL_W-1:0]  master_r;
  logic [POS_W-1:0]  fstart_r, flen_r;
  logic              ended_r;
  logic [POS_W-1:0]  pos_r;
  logic signed [SAMPLE_W-1:0] xl_r, xr_r;
  logic              kill_r;
  logic [POS_W-1:0]  rem_r;
  logic [QUOT_W-1:0] q_r;
  logic [VOL_W-1:0]  gain_r;
  logic signed [55:0] prod_r;
  logic signed [OUT_W-1:0] left_r;

  logic              out_valid_r;
  logic signed [OUT_W-1:0] out_left_r, out_right_r;
  logic              out_sv_r, out_done_r;

  logic              ge;
  logic [POS_W-1:0]  d;
  logic              end_hit;
  logic [POS_W:0]    rem2, rem_sub;
  logic              geq;
  logic [QUOT_W:0]   f;
  logic signed [34:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [55:0] prod;
  logic              cfg_hit;
  logic              fin_wr;

  assign ge      = (pos_r >= fstart_r);
  assign d       = pos_r - fstart_r;
  assign end_hit = !ended_r && ge && (d >= flen_r);

  assign rem2    = {rem_r, 1'b0};
  assign rem_sub = rem2 - {1'b0, flen_r};
  assign geq     = (rem2 >= {1'b0, flen_r});
  assign f       = UNITY_GAIN - {1'b0, q_r};

  always_comb begin
    priority if (ctl.mul_ff) begin
      mul_a = 35'({18'd0, f});
      mul_b = 21'({4'd0, f});
    end else if (ctl.mul_g) begin
      mul_a = {1'b0, prod_r[33:0]};
      mul_b = {1'b0, master_r};
    end else if (ctl.mul_l) begin
      mul_a = 35'(xl_r);
      mul_b = {1'b0, gain_r};
    end else if (ctl.mul_r) begin
      mul_a = 35'(xr_r);
      mul_b = {1'b0, gain_r};
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
  end

  assign prod = 56'(mul_a) * 56'(mul_b);

  assign cfg_hit = cfg_valid && cfg_ready &&
                   (cfg_index == REG_MASTER_VOLUME || cfg_index == REG_FADE_START ||
                    cfg_index == REG_FADE_LENGTH);
  assign fin_wr  = ctl.fin && !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= MASTER_RESET;
      fstart_r <= FADE_START_RESET;
      flen_r   <= FADE_LENGTH_RESET;
      ended_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MASTER_VOLUME: master_r <= cfg_data[VOL_W-1:0];
          REG_FADE_START:    fstart_r <= cfg_data;
          REG_FADE_LENGTH:   flen_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) ended_r <= 1'b0;
      else if (ctl.check && end_hit) ended_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (fin_wr) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      pos_r <= in_sample_pos;
      xl_r  <= in_left_in;
      xr_r  <= in_right_in;
    end
    if (ctl.check) begin
      kill_r <= end_hit;
      rem_r  <= d;
      q_r    <= '0;
      gain_r <= (ended_r || ge) ? '0 : master_r;
    end
    if (ctl.div) begin
      rem_r <= geq ? rem_sub[POS_W-1:0] : rem2[POS_W-1:0];
      q_r   <= {q_r[QUOT_W-2:0], geq};
    end
    if (ctl.mul_ff || ctl.mul_g || ctl.mul_l || ctl.mul_r) prod_r <= prod;
    if (ctl.ld_g) gain_r <= prod_r[51:32];
    if (ctl.mul_r) left_r <= sat16(prod_r);
    if (fin_wr) begin
      out_left_r  <= kill_r ? '0 : left_r;
      out_right_r <= kill_r ? '0 : sat16(prod_r);
      out_sv_r    <= !kill_r;
      out_done_r  <= ended_r;
    end
  end

  assign stat.end_hit  = end_hit;
  assign stat.need_div = !ended_r && ge && !end_hit;
  assign stat.out_busy = out_valid_r && out_stall;
  assign stat.ended    = ended_r;

  assign out_valid        = out_valid_r;
  assign out_left_out     = out_left_r;
  assign out_right_out    = out_right_r;
  assign out_sample_valid = out_sv_r;
  assign out_fade_done    = out_done_r;

endmodule
